// ===== src/stq_pkg.sv =====
// Package for the sorted timer queue: sizes, mode codes, cell command struct, saturating add.
// No dependencies.
package stq_pkg;
	localparam int SLOTS     = 16;
	localparam int MAX_FIRES = 16;
	localparam int ID_W      = 4;
	localparam int CNT_W     = 5;
	localparam int DL_W      = 63;
	localparam int PER_W     = 40;
	localparam int MINP_W    = 20;
	localparam int FIRE_CAP  = (MAX_FIRES < 16) ? MAX_FIRES : 16;
	localparam logic [MINP_W-1:0] MIN_PERIOD_RESET = 20'd100000;
	localparam logic [DL_W-1:0]   DL_MAX = {DL_W{1'b1}};

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_DEL  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic            rem;  // remove entry holding rem_id, shift up behind it
		logic [ID_W-1:0] rem_id;
		logic            ins;  // insert ins_id at its sorted place
		logic [ID_W-1:0] ins_id;
		logic [DL_W-1:0] ins_dl;
	} cell_cmd_t;

	function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
			input logic [PER_W-1:0] b);
		logic [DL_W:0] s;
		s = {1'b0, a} + {{(DL_W+1-PER_W){1'b0}}, b};
		return s[DL_W] ? DL_MAX : s[DL_W-1:0];
	endfunction
endpackage

// ===== src/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: sequencer, slot tables, chain of cells.
// Depends on stq_pkg and stq_cell.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  input   | in_valid  | in_stall  | mode timer_id timer_kind period_ns now_ns
//  output  | out_valid | out_stall | status fired fired_id head_changed
//          |           |           | next_deadline last
//  config  | cfg_we    | -         | cfg_data (min_period_ns)
//
// With no output stall an add runs through accept, remove, deadline, insert and
// present, hand-off and return to idle; a delete, or a periodic add whose period
// is below the minimum, skips the deadline step. A tick runs accept and return to
// idle plus, per fired one-shot timer, pop, remove, present and hand-off, with
// deadline and re-insert on top per fired periodic timer. Each remove or insert
// shifts the whole chain of 16 cells at once.
// Reset empties the chain and clears the slot tables at once; no sweep.
// A stalled result holds in the output register and adds its stall cycles to the
// hand-off; the next transaction is taken only after the current one has
// delivered all its results.
module sorted_timer_queue import stq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [ID_W-1:0]   timer_id,
	input  logic              timer_kind,
	input  logic [PER_W-1:0]  period_ns,
	input  logic [DL_W-1:0]   now_ns,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic              fired,
	output logic [ID_W-1:0]   fired_id,
	output logic              head_changed,
	output logic [DL_W-1:0]   next_deadline,
	output logic              last,
	input  logic              cfg_we,
	input  logic [MINP_W-1:0] cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REM  = 3'd1; // remove slot from chain
	localparam logic [2:0] ST_CALC = 3'd2; // work out deadline
	localparam logic [2:0] ST_INS  = 3'd3; // insert into chain
	localparam logic [2:0] ST_OUT  = 3'd4; // hold result until taken
	localparam logic [2:0] ST_TCHK = 3'd5; // tick: check head

	logic [2:0]            st_q;
	logic [MINP_W-1:0]     minp_q;
	logic [1:0]            mode_q;
	logic [ID_W-1:0]       id_q;
	logic                  kind_q;
	logic [PER_W-1:0]      per_q;
	logic [DL_W-1:0]       now_q;
	logic [DL_W-1:0]       newdl_q;
	logic                  was_head_q;
	logic                  ticking_q;
	logic                  fire_pend_q;
	logic [CNT_W-1:0]      nfire_q;

	logic [DL_W-1:0]  slot_dl_q  [SLOTS];
	logic [PER_W-1:0] slot_per_q [SLOTS];
	logic [SLOTS-1:0] slot_kind_q;
	logic [SLOTS-1:0] slot_qd_q;

	logic              o_valid_q, o_status_q, o_fired_q, o_hc_q, o_last_q;
	logic [ID_W-1:0]   o_id_q;

	cell_cmd_t        cmd;
	logic [SLOTS-1:0] cv;
	logic [ID_W-1:0]  cid [SLOTS];
	logic [DL_W-1:0]  cdl [SLOTS];
	logic [SLOTS:0]   ins_ch, past_ch;

	assign ins_ch[0]  = 1'b0;
	assign past_ch[0] = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		stq_cell u_cell (
			.clk, .arst_n, .cmd,
			.prev_v       (i == 0 ? 1'b0 : cv[(i == 0) ? 0 : i-1]),
			.prev_id      (cid[(i == 0) ? 0 : i-1]),
			.prev_dl      (cdl[(i == 0) ? 0 : i-1]),
			.prev_ins_here(ins_ch[i]),
			.prev_past    (past_ch[i]),
			.next_v       (i == SLOTS-1 ? 1'b0 : cv[(i == SLOTS-1) ? i : i+1]),
			.next_id      (cid[(i == SLOTS-1) ? i : i+1]),
			.next_dl      (cdl[(i == SLOTS-1) ? i : i+1]),
			.v            (cv[i]),
			.id           (cid[i]),
			.dl           (cdl[i]),
			.ins_here     (ins_ch[i+1]),
			.past         (past_ch[i+1])
		);
	end

	// First queued periodic entry with a matching period, in queue order.
	logic             match_f;
	logic [DL_W-1:0]  match_dl;
	always_comb begin
		match_f  = 1'b0;
		match_dl = '0;
		for (int i = SLOTS-1; i >= 0; i--) begin
			if (cv[i] && slot_kind_q[cid[i]] && slot_per_q[cid[i]] == per_q) begin
				match_f  = 1'b1;
				match_dl = cdl[i];
			end
		end
	end

	logic [PER_W-1:0] rel_per;
	logic [DL_W-1:0]  base_dl;
	assign rel_per = (per_q == '0) ? {{(PER_W-1){1'b0}}, 1'b1} : per_q;
	always_comb begin
		if (slot_dl_q[id_q] != '0) base_dl = slot_dl_q[id_q];
		else if (match_f)          base_dl = match_dl;
		else                       base_dl = now_q;
	end

	logic short_per;
	assign short_per = per_q < {{(PER_W-MINP_W){1'b0}}, minp_q};

	// Head has expired and the tick still has room for another fire.
	logic more_fire;
	assign more_fire = cv[0] && cdl[0] <= now_q && nfire_q < CNT_W'(FIRE_CAP);

	always_comb begin
		cmd        = '0;
		cmd.rem_id = id_q;
		cmd.ins_id = id_q;
		cmd.ins_dl = newdl_q;
		if (st_q == ST_REM) cmd.rem = slot_qd_q[id_q];
		if (st_q == ST_INS && (ticking_q || mode_q == MODE_ADD) && !(mode_q == MODE_ADD
				&& kind_q && short_per && !ticking_q))
			cmd.ins = 1'b1;
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = o_valid_q;
	assign status       = o_status_q;
	assign fired        = o_fired_q;
	assign fired_id     = o_id_q;
	assign head_changed = o_hc_q;
	assign last         = o_last_q;
	assign next_deadline = cv[0] ? cdl[0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) minp_q <= MIN_PERIOD_RESET;
		else if (cfg_we) minp_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q <= mode;
			id_q   <= timer_id;
			kind_q <= timer_kind;
			per_q  <= period_ns;
			now_q  <= now_ns;
		end else if (st_q == ST_TCHK && more_fire && !fire_pend_q && !o_valid_q) begin
			// pop the head: reuse the slot fields of the expired entry
			id_q   <= cid[0];
			kind_q <= slot_kind_q[cid[0]];
			per_q  <= slot_per_q[cid[0]];
		end
		if (st_q == ST_REM) was_head_q <= cv[0] && cid[0] == id_q && slot_qd_q[id_q];
		if (st_q == ST_CALC) begin
			if (kind_q) newdl_q <= sat_add(base_dl, per_q);
			else        newdl_q <= sat_add(now_q, rel_per);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			o_valid_q <= 1'b0;
			ticking_q <= 1'b0;
			fire_pend_q <= 1'b0;
			nfire_q <= '0;
			slot_kind_q <= '0;
			slot_qd_q <= '0;
			o_status_q <= 1'b0; o_fired_q <= 1'b0; o_hc_q <= 1'b0;
			o_last_q <= 1'b0; o_id_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_dl_q[i]  <= '0;
				slot_per_q[i] <= '0;
			end
		end else begin
			if (o_valid_q && !out_stall) o_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						ticking_q   <= 1'b0;
						fire_pend_q <= 1'b0;
						nfire_q     <= '0;
						unique case (mode)
							MODE_ADD, MODE_DEL: st_q <= ST_REM;
							MODE_TICK: st_q <= ST_TCHK;
							default: begin
								o_valid_q <= 1'b1; o_status_q <= 1'b0;
								o_fired_q <= 1'b0; o_hc_q <= 1'b0;
								o_id_q <= '0; o_last_q <= 1'b1;
								st_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_REM: begin
					slot_qd_q[id_q] <= 1'b0;
					if (ticking_q) begin
						if (kind_q) st_q <= ST_CALC;
						else        st_q <= ST_TCHK;
					end else if (mode_q == MODE_DEL) begin
						st_q <= ST_INS;
					end else if (kind_q && short_per) begin
						st_q <= ST_INS;
					end else begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (!ticking_q) begin
						slot_kind_q[id_q] <= kind_q;
						slot_per_q[id_q]  <= kind_q ? per_q : rel_per;
					end
					st_q <= ST_INS;
				end
				ST_INS: begin
					if (cmd.ins) begin
						slot_qd_q[id_q] <= 1'b1;
						slot_dl_q[id_q] <= newdl_q;
					end
					if (ticking_q) begin
						st_q <= ST_TCHK;
					end else begin
						o_valid_q  <= 1'b1;
						o_fired_q  <= 1'b0;
						o_id_q     <= '0;
						o_last_q   <= 1'b1;
						o_status_q <= (mode_q == MODE_ADD) && kind_q && short_per;
						if (mode_q == MODE_DEL)
							o_hc_q <= was_head_q && (cv[0] | cv[1]) && cv[0];
						else
							o_hc_q <= cmd.ins && ins_ch[1];
						st_q <= ST_OUT;
					end
				end
				ST_TCHK: begin
					// wait until the previous fired result has been taken
					if (!o_valid_q) begin
						if (fire_pend_q) begin
							// present the fired timer with the head left after its re-queue
							o_valid_q   <= 1'b1;
							o_last_q    <= !more_fire;
							fire_pend_q <= 1'b0;
							if (!more_fire) st_q <= ST_OUT;
						end else if (more_fire) begin
							ticking_q   <= 1'b1;
							fire_pend_q <= 1'b1;
							nfire_q     <= nfire_q + 1'b1;
							o_fired_q   <= 1'b1;
							o_id_q      <= cid[0];
							o_status_q  <= 1'b0;
							o_hc_q      <= 1'b0;
							st_q <= ST_REM;
						end else begin
							// nothing expired
							o_valid_q  <= 1'b1;
							o_last_q   <= 1'b1;
							o_fired_q  <= 1'b0;
							o_id_q     <= '0;
							o_status_q <= 1'b0;
							o_hc_q     <= 1'b0;
							st_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!o_valid_q) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== src/stq_cell.sv =====
// One position of the sorted queue: holds a slot id and its deadline.
// Depends on stq_pkg.
module stq_cell import stq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_cmd_t       cmd,
	input  logic            prev_v,
	input  logic [ID_W-1:0] prev_id,
	input  logic [DL_W-1:0] prev_dl,
	input  logic            prev_ins_here, // new entry lands before this cell
	input  logic            prev_past,     // removal point at or before previous
	input  logic            next_v,
	input  logic [ID_W-1:0] next_id,
	input  logic [DL_W-1:0] next_dl,
	output logic            v,
	output logic [ID_W-1:0] id,
	output logic [DL_W-1:0] dl,
	output logic            ins_here,
	output logic            past
);
	logic            v_q;
	logic [ID_W-1:0] id_q;
	logic [DL_W-1:0] dl_q;

	assign v  = v_q;
	assign id = id_q;
	assign dl = dl_q;
	// removal passes the matching cell on to every later one
	assign past = prev_past | (cmd.rem & v_q & (id_q == cmd.rem_id));
	// insertion point: first valid cell later than the new deadline, or first empty
	assign ins_here = prev_ins_here | (cmd.ins & (~v_q | (dl_q > cmd.ins_dl)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (past) begin
			v_q <= next_v;
		end else if (ins_here && !prev_ins_here) begin
			v_q <= 1'b1;
		end else if (prev_ins_here) begin
			v_q <= prev_v;
		end
	end

	always_ff @(posedge clk) begin
		if (past) begin
			id_q <= next_id;
			dl_q <= next_dl;
		end else if (ins_here && !prev_ins_here) begin
			id_q <= cmd.ins_id;
			dl_q <= cmd.ins_dl;
		end else if (prev_ins_here) begin
			id_q <= prev_id;
			dl_q <= prev_dl;
		end
	end
endmodule

// ===== dv/sorted_timer_queue_tb.sv =====
// Self-checking testbench for sorted_timer_queue: directed and random timer transactions,
// checked result by result against a timer-queue predictor kept inside the bench.
// Depends on stq_pkg and the sorted_timer_queue RTL.
module sorted_timer_queue_tb;
	import stq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]       mode;
		logic [ID_W-1:0]  id;
		logic             kind;
		logic [PER_W-1:0] period;
		logic [DL_W-1:0]  now;
	} timer_req_t;

	typedef struct {
		logic            status;
		logic            fired;
		logic [ID_W-1:0] fired_id;
		logic            head_changed;
		logic [DL_W-1:0] next_deadline;
		logic            last;
	} timer_rsp_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        mode;
	logic [ID_W-1:0]   timer_id;
	logic              timer_kind;
	logic [PER_W-1:0]  period_ns;
	logic [DL_W-1:0]   now_ns;
	logic              out_valid;
	logic              out_stall;
	logic              status;
	logic              fired;
	logic [ID_W-1:0]   fired_id;
	logic              head_changed;
	logic [DL_W-1:0]   next_deadline;
	logic              last;
	logic              cfg_we;
	logic [MINP_W-1:0] cfg_data;

	sorted_timer_queue dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .timer_id(timer_id), .timer_kind(timer_kind),
		.period_ns(period_ns), .now_ns(now_ns),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .fired(fired), .fired_id(fired_id),
		.head_changed(head_changed), .next_deadline(next_deadline), .last(last),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Pending transactions for the driver and results the queue still owes us.
	timer_req_t req_q[$];
	timer_rsp_t rsp_q[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req_n;
	int hold_seen_n;
	int hold_left;
	bit in_taken;
	int mismatches;
	int unexpected;
	int rsp_checked;
	int fires_seen;
	int cycles;
	logic [DL_W-1:0] cur_now;

	// Predictor state: a private copy of the slot tables and the sorted order.
	logic [MINP_W-1:0] pm_min_period;
	logic [DL_W-1:0]   pm_dl[SLOTS];
	logic [PER_W-1:0]  pm_per[SLOTS];
	logic              pm_kind[SLOTS];
	logic              pm_queued[SLOTS];
	int                pm_order[SLOTS];
	int                pm_count;

	function automatic logic [DL_W-1:0] add_clamped(logic [DL_W-1:0] a, logic [PER_W-1:0] b);
		logic [DL_W:0] s;
		s = {1'b0, a} + {{(DL_W+1-PER_W){1'b0}}, b};
		return s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
	endfunction

	function automatic logic [DL_W-1:0] head_dl();
		return (pm_count == 0) ? '0 : pm_dl[pm_order[0]];
	endfunction

	function automatic int unlink_slot(int id);
		int pos;
		if (!pm_queued[id]) return -1;
		pm_queued[id] = 1'b0;
		pos = -1;
		for (int i = 0; i < pm_count; i++)
			if (pos < 0 && pm_order[i] == id) pos = i;
		if (pos < 0) return -1;
		for (int i = pos; i < pm_count - 1; i++) pm_order[i] = pm_order[i+1];
		pm_count--;
		return pos;
	endfunction

	function automatic int link_slot(int id);
		int pos;
		pos = 0;
		while (pos < pm_count && pm_dl[pm_order[pos]] <= pm_dl[id]) pos++;
		for (int i = pm_count; i > pos; i--) pm_order[i] = pm_order[i-1];
		pm_order[pos] = id;
		pm_count++;
		pm_queued[id] = 1'b1;
		return pos;
	endfunction

	// Advance a periodic deadline; a blank one borrows from a queued peer of equal period.
	function automatic void step_periodic(int id, logic [DL_W-1:0] now);
		logic [DL_W-1:0] base;
		bit found;
		if (pm_dl[id] == 0) begin
			base = now;
			found = 0;
			for (int i = 0; i < pm_count; i++) begin
				if (!found && pm_kind[pm_order[i]] && pm_per[pm_order[i]] == pm_per[id]) begin
					base = pm_dl[pm_order[i]];
					found = 1;
				end
			end
			pm_dl[id] = base;
		end
		pm_dl[id] = add_clamped(pm_dl[id], pm_per[id]);
	endfunction

	function automatic void owe(logic st, logic fi, int fid, logic hc, logic lst);
		timer_rsp_t r;
		r.status = st;
		r.fired = fi;
		r.fired_id = fid[ID_W-1:0];
		r.head_changed = hc;
		r.next_deadline = head_dl();
		r.last = lst;
		rsp_q.push_back(r);
	endfunction

	function automatic void predict_timer(timer_req_t t);
		int id;
		int pos;
		int n;
		int top;
		logic [PER_W-1:0] per;
		id = int'(t.id);
		case (t.mode)
			MODE_ADD: begin
				void'(unlink_slot(id));
				if (t.kind && t.period < pm_min_period) begin
					owe(1'b1, 1'b0, 0, 1'b0, 1'b1);
				end else begin
					if (t.kind) begin
						pm_kind[id] = 1'b1;
						pm_per[id] = t.period;
						step_periodic(id, t.now);
					end else begin
						per = (t.period == 0) ? 40'd1 : t.period;
						pm_kind[id] = 1'b0;
						pm_per[id] = per;
						pm_dl[id] = add_clamped(t.now, per);
					end
					pos = link_slot(id);
					owe(1'b0, 1'b0, 0, pos == 0, 1'b1);
				end
			end
			MODE_DEL: begin
				pos = unlink_slot(id);
				owe(1'b0, 1'b0, 0, pos == 0 && pm_count > 0, 1'b1);
			end
			MODE_TICK: begin
				n = 0;
				while (n < FIRE_CAP && pm_count > 0 && head_dl() <= t.now) begin
					top = pm_order[0];
					void'(unlink_slot(top));
					if (pm_kind[top]) begin
						step_periodic(top, t.now);
						void'(link_slot(top));
					end
					owe(1'b0, 1'b1, top, 1'b0, 1'b0);
					n++;
				end
				if (n == 0) owe(1'b0, 1'b0, 0, 1'b0, 1'b1);
				else rsp_q[rsp_q.size()-1].last = 1'b1;
			end
			default: owe(1'b0, 1'b0, 0, 1'b0, 1'b1);
		endcase
	endfunction

	task automatic queue_req(logic [1:0] m, int id, logic k, logic [PER_W-1:0] p,
			logic [DL_W-1:0] n);
		timer_req_t t;
		t.mode = m;
		t.id = id[ID_W-1:0];
		t.kind = k;
		t.period = p;
		t.now = n;
		req_q.push_back(t);
	endtask

	// Mostly well-formed traffic around a slowly advancing clock, some noise.
	task automatic queue_random_req();
		int r;
		logic [PER_W-1:0] p;
		r = $urandom_range(99);
		if (r < 45) begin
			if ($urandom_range(1)) begin
				if ($urandom_range(9) == 0 && pm_min_period > 0)
					p = PER_W'(pm_min_period) - 40'd1 -
						PER_W'($urandom_range(pm_min_period - 1 < 50 ?
						pm_min_period - 1 : 50));
				else
					p = PER_W'(pm_min_period) + PER_W'($urandom_range(400000));
				queue_req(MODE_ADD, $urandom_range(SLOTS-1), 1'b1, p, cur_now);
			end else begin
				p = ($urandom_range(7) == 0) ? 40'd0 : 40'($urandom_range(300000));
				queue_req(MODE_ADD, $urandom_range(SLOTS-1), 1'b0, p, cur_now);
			end
		end else if (r < 60) begin
			queue_req(MODE_DEL, $urandom_range(SLOTS-1), 1'($urandom_range(1)),
				PER_W'({$urandom, $urandom}), DL_W'({$urandom, $urandom}));
		end else if (r < 92) begin
			cur_now = cur_now + DL_W'($urandom_range(250000));
			queue_req(MODE_TICK, $urandom_range(SLOTS-1), 1'($urandom_range(1)),
				PER_W'({$urandom, $urandom}), cur_now);
		end else if (r < 95) begin
			queue_req(2'd3, $urandom_range(SLOTS-1), 1'($urandom_range(1)),
				PER_W'({$urandom, $urandom}), DL_W'({$urandom, $urandom}));
		end else begin
			// Fully random fields: drives the top bits of period and time too.
			queue_req(MODE_ADD, $urandom_range(SLOTS-1), 1'($urandom_range(1)),
				PER_W'({$urandom, $urandom}), DL_W'({$urandom, $urandom}));
		end
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (req_q.size() != 0 || in_valid || rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_period(logic [MINP_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		pm_min_period = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results still owed", cycles, rsp_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Monitor: check every delivered result, then log the accepted transaction.
	always @(posedge clk) begin
		timer_rsp_t e;
		timer_req_t t;
		if (arst_n && out_valid && !out_stall) begin
			if (rsp_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("Unexpected result: fired=%0d id=%0d next=%0d", fired,
						fired_id, next_deadline);
			end else begin
				e = rsp_q.pop_front();
				rsp_checked++;
				if (fired) fires_seen++;
				if (status !== e.status || fired !== e.fired || fired_id !== e.fired_id ||
						head_changed !== e.head_changed ||
						next_deadline !== e.next_deadline || last !== e.last) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display({"Mismatch: exp st=%0d fi=%0d id=%0d hc=%0d nd=%0d last=%0d,",
							" got st=%0d fi=%0d id=%0d hc=%0d nd=%0d last=%0d"},
							e.status, e.fired, e.fired_id, e.head_changed,
							e.next_deadline, e.last, status, fired, fired_id,
							head_changed, next_deadline, last);
				end
			end
		end
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			t.mode = mode;
			t.id = timer_id;
			t.kind = timer_kind;
			t.period = period_ns;
			t.now = now_ns;
			predict_timer(t);
		end
	end

	// Driver: hold a stalled transaction, otherwise offer the next one or idle.
	always @(negedge clk) begin
		timer_req_t t;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				t = req_q.pop_front();
				in_valid <= 1'b1;
				mode <= t.mode;
				timer_id <= t.id;
				timer_kind <= t.kind;
				period_ns <= t.period;
				now_ns <= t.now;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_req_n != hold_seen_n) begin
			hold_seen_n = hold_req_n;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	initial begin
		int cfg_plan[6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		mode = MODE_ADD;
		timer_id = '0;
		timer_kind = 1'b0;
		period_ns = '0;
		now_ns = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		tx_idle_pct = 24;
		rx_idle_pct = 67;
		hold_req_n = 0;
		hold_seen_n = 0;
		hold_left = 0;
		in_taken = 0;
		mismatches = 0;
		unexpected = 0;
		rsp_checked = 0;
		fires_seen = 0;
		cycles = 0;
		cur_now = 63'd1000;
		pm_min_period = MIN_PERIOD_RESET;
		pm_count = 0;
		for (int i = 0; i < SLOTS; i++) begin
			pm_dl[i] = '0;
			pm_per[i] = '0;
			pm_kind[i] = 1'b0;
			pm_queued[i] = 1'b0;
			pm_order[i] = 0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset value of the minimum period.
		queue_req(MODE_ADD, 0, 1'b1, 40'd200000, 63'd1000);   // blank deadline takes now
		queue_req(MODE_ADD, 1, 1'b1, 40'd200000, 63'd5000);   // borrows slot 0's deadline
		queue_req(MODE_ADD, 2, 1'b1, 40'd99999, 63'd5000);    // period below minimum
		queue_req(MODE_ADD, 3, 1'b0, 40'd0, 63'd2000);        // zero delay becomes one
		queue_req(MODE_ADD, 4, 1'b0, {PER_W{1'b1}}, DL_MAX - 5); // saturating deadline
		queue_req(MODE_ADD, 15, 1'b0, 40'd50, 63'd1000);      // new head
		queue_req(MODE_ADD, 14, 1'b0, 40'd1050, 63'd0);       // ties go behind
		queue_req(MODE_ADD, 3, 1'b0, 40'd10, 63'd1000);       // modify a queued slot
		queue_req(MODE_DEL, 15, 1'b0, 40'd0, 63'd0);          // delete the second entry
		queue_req(MODE_DEL, 9, 1'b1, {PER_W{1'b1}}, DL_MAX);  // delete an idle slot
		queue_req(MODE_TICK, 0, 1'b0, 40'd0, 63'd500);        // nothing expired
		queue_req(MODE_TICK, 0, 1'b0, 40'd0, 63'd1050);
		queue_req(2'd3, 15, 1'b1, {PER_W{1'b1}}, DL_MAX);     // unused mode
		queue_req(MODE_TICK, 15, 1'b1, {PER_W{1'b1}}, 63'd401000);
		queue_req(MODE_ADD, 2, 1'b1, {PER_W{1'b1}}, 63'd2000);
		for (int i = 5; i < 14; i++) queue_req(MODE_ADD, i, 1'b0, 40'(i * 7), 63'd3000);
		queue_req(MODE_TICK, 0, 1'b0, 40'd0, 63'd10000000);   // periodic refires hit the cap
		queue_req(MODE_TICK, 0, 1'b0, 40'd0, DL_MAX);
		wait_idle();
		for (int i = 0; i < SLOTS; i++) queue_req(MODE_DEL, i, 1'b0, 40'd0, 63'd0);
		wait_idle();

		cfg_plan[0] = 1;
		cfg_plan[1] = 1048575;
		cfg_plan[2] = $urandom_range(1048575, 1);
		cfg_plan[3] = 100000;
		cfg_plan[4] = $urandom_range(200000, 1);
		cfg_plan[5] = 1;
		cur_now = 63'd20000000;
		for (int ph = 0; ph < 6; ph++) begin
			write_min_period(cfg_plan[ph][MINP_W-1:0]);
			case (ph % 3)
				0: begin tx_idle_pct = 24; rx_idle_pct = 67; end
				1: begin tx_idle_pct = 67; rx_idle_pct = 24; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int k = 0; k < 65; k++) queue_random_req();
			// Starve the output while the sender keeps offering: input must back up.
			if (ph == 2 || ph == 5) hold_req_n++;
			wait_idle();
		end

		$display("Covered %0d checked results including %0d fired timers, six settings",
			rsp_checked, fires_seen);
		$display("of the minimum period and three idle profiles with long output hold-offs.");
		if (mismatches == 0 && unexpected == 0 && rsp_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
				rsp_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/stq_pkg.sv
src/stq_cell.sv
src/sorted_timer_queue.sv
dv/sorted_timer_queue_tb.sv
